### hdl/cscf_pkg.sv
`timescale 1ns / 1ps
// Package for the curtain servo and fan controller.
// Shared types, register indexes and constants; no dependencies.
package cscf_pkg;

    // Request kinds carried in req_type
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_BUTTON = 2'd2
    } req_kind_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_HIGH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP    = 2'd3;

    // Register reset values
    localparam logic [6:0] LIGHT_HIGH_RST   = 7'd70;
    localparam logic [6:0] LIGHT_LOW_RST    = 7'd30;
    localparam logic [7:0] SETTLE_TICKS_RST = 8'd100;
    localparam logic [9:0] RAMP_STEP_RST    = 10'd20;

    // Servo pulse bounds in microseconds
    localparam logic [10:0] PULSE_MIN = 11'd1000;
    localparam logic [10:0] PULSE_MAX = 11'd2000;
    localparam logic signed [12:0] PULSE_MIN_S = 13'sd1000;
    localparam logic signed [12:0] PULSE_MAX_S = 13'sd2000;

    // Fan duty in tenths of a percent
    localparam logic [9:0] FAN_FULL = 10'd1000;
    localparam logic [9:0] FAN_BASE = 10'd350;
    localparam logic signed [12:0] TEMP_ON = 13'sd250;
    // Above this excess over TEMP_ON the linear duty passes full scale
    localparam logic signed [12:0] TEMP_SAT_EXCESS = 13'sd100;
    // Slope 6.5 per tenth of a degree, taken as 13/2
    localparam logic [10:0] FAN_SLOPE_X2 = 11'd13;

    typedef struct packed {
        logic [6:0] light_high;
        logic [6:0] light_low;
        logic [7:0] settle_ticks;
        logic [9:0] ramp_step;
    } cscf_cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  light_pct;
        logic signed [11:0] temp_tenths;
        logic        limit_open;
        logic        limit_closed;
        logic        window_open;
        logic        presence;
        logic        rain;
        logic        cinema;
        logic        vent_max;
    } cscf_item_t;

    typedef struct packed {
        logic        manual_mode;
        logic        target_open;
        logic        physical_open;
        logic        moving;
        logic [7:0]  settle_count;
        logic [10:0] pulse;
        logic [9:0]  fan;
    } cscf_state_t;

endpackage

### hdl/cscf_req_if.sv
`timescale 1ns / 1ps
// Input channel of the curtain servo and fan controller.
// Valid/ready handshake with the request fields; no dependencies.
interface cscf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [6:0]  light_pct;
    logic signed [11:0] temp_tenths;
    logic        limit_open;
    logic        limit_closed;
    logic        window_open;
    logic        presence;
    logic        rain;
    logic        cinema;
    logic        vent_max;

    modport source (
        output valid, req_type, light_pct, temp_tenths, limit_open, limit_closed,
               window_open, presence, rain, cinema, vent_max,
        input  ready
    );
    modport sink (
        input  valid, req_type, light_pct, temp_tenths, limit_open, limit_closed,
               window_open, presence, rain, cinema, vent_max,
        output ready
    );
endinterface

### hdl/cscf_res_if.sv
`timescale 1ns / 1ps
// Result channel of the curtain servo and fan controller.
// Valid/ready handshake with the status fields; no dependencies.
interface cscf_res_if;
    logic        valid;
    logic        ready;
    logic [10:0] servo_pulse;
    logic [9:0]  fan_level;
    logic        curtain_is_open;
    logic        auto_on;
    logic        fan_on;
    logic        in_motion;

    modport source (
        output valid, servo_pulse, fan_level, curtain_is_open, auto_on, fan_on,
               in_motion,
        input  ready
    );
    modport sink (
        input  valid, servo_pulse, fan_level, curtain_is_open, auto_on, fan_on,
               in_motion,
        output ready
    );
endinterface

### hdl/cscf_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the curtain servo and fan controller.
// Register index and write data with valid/ready; no dependencies.
interface cscf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/cscf_step.sv
`timescale 1ns / 1ps
// Next-state logic for one request word: servo ramp, settle counter,
// curtain target, fan duty and manual mode. Depends on cscf_pkg.
module cscf_step (
    input  cscf_pkg::cscf_cfg_t   cfg,
    input  cscf_pkg::cscf_item_t  item,
    input  cscf_pkg::cscf_state_t cur,
    output cscf_pkg::cscf_state_t nxt
);

    logic signed [12:0] pulse_s;
    logic signed [12:0] pulse_up;
    logic signed [12:0] pulse_dn;
    logic signed [12:0] pulse_o;
    logic signed [12:0] pulse_c;
    logic [7:0]         cnt_inc;
    logic signed [12:0] temp_ext;
    logic signed [12:0] excess;
    logic [10:0]        slope_x2;
    logic [9:0]         fan_lin;
    logic               target_s;

    // Ramp candidates, wide enough to hold overshoot either way
    assign pulse_s  = $signed({2'b00, cur.pulse});
    assign pulse_up = pulse_s + $signed({3'b000, cfg.ramp_step});
    assign pulse_dn = pulse_s - $signed({3'b000, cfg.ramp_step});
    assign pulse_o  = item.limit_open ? pulse_s : pulse_up;
    assign pulse_c  = item.limit_closed ? pulse_s : pulse_dn;
    assign cnt_inc  = cur.settle_count + 8'd1;

    // Fan: 350 + floor(excess * 13 / 2), only used below saturation
    assign temp_ext = $signed({item.temp_tenths[11], item.temp_tenths});
    assign excess   = temp_ext - cscf_pkg::TEMP_ON;
    assign slope_x2 = {4'b0000, excess[6:0]} * cscf_pkg::FAN_SLOPE_X2;
    assign fan_lin  = cscf_pkg::FAN_BASE + slope_x2[10:1];

    // Curtain target: light hysteresis, then closing forces, then window
    always_comb
    begin
        target_s = cur.target_open;
        if (item.light_pct > cfg.light_high)
            target_s = 1'b1;
        else if (item.light_pct < cfg.light_low)
            target_s = 1'b0;
        if (item.rain || item.cinema)
            target_s = 1'b0;
        if (item.window_open)
            target_s = 1'b1;
    end

    always_comb
    begin
        nxt = cur;
        case (item.req_type)
            cscf_pkg::REQ_TICK:
            begin
                if (!cur.manual_mode)
                begin
                    if (cur.moving)
                    begin
                        if (cur.target_open)
                        begin
                            nxt.pulse = pulse_o[10:0];
                            if (pulse_o >= cscf_pkg::PULSE_MAX_S || item.limit_open)
                            begin
                                if (pulse_o > cscf_pkg::PULSE_MAX_S)
                                    nxt.pulse = cscf_pkg::PULSE_MAX;
                                nxt.moving        = 1'b0;
                                nxt.physical_open = 1'b1;
                            end
                        end
                        else
                        begin
                            nxt.pulse = pulse_c[10:0];
                            if (pulse_c <= cscf_pkg::PULSE_MIN_S || item.limit_closed)
                            begin
                                if (pulse_c < cscf_pkg::PULSE_MIN_S)
                                    nxt.pulse = cscf_pkg::PULSE_MIN;
                                nxt.moving        = 1'b0;
                                nxt.physical_open = 1'b0;
                            end
                        end
                    end
                    else if (cur.target_open != cur.physical_open)
                    begin
                        if (cnt_inc >= cfg.settle_ticks)
                        begin
                            nxt.moving       = 1'b1;
                            nxt.settle_count = 8'd0;
                        end
                        else
                            nxt.settle_count = cnt_inc;
                    end
                    else
                        nxt.settle_count = 8'd0;
                end
            end
            cscf_pkg::REQ_SAMPLE:
            begin
                nxt.target_open = target_s;
                if (item.vent_max)
                    nxt.fan = cscf_pkg::FAN_FULL;
                else if (!item.window_open && item.presence && excess > 13'sd0
                         && !cur.manual_mode)
                begin
                    if (excess > cscf_pkg::TEMP_SAT_EXCESS)
                        nxt.fan = cscf_pkg::FAN_FULL;
                    else
                        nxt.fan = fan_lin;
                end
                else
                    nxt.fan = 10'd0;
            end
            cscf_pkg::REQ_BUTTON:
                nxt.manual_mode = !cur.manual_mode;
            default:
                nxt = cur;
        endcase
    end

endmodule

### hdl/curtain_servo_and_fan_controller_top.sv
`timescale 1ns / 1ps
// Top level of the curtain servo and fan controller.
// Depends on cscf_pkg, the three channel interfaces and cscf_step.
//
// Usage:
//   req  - request words: a 100 ms tick, a sensor sample or a button press.
//   res  - one status word per request: servo pulse, fan duty and flags,
//          reflecting the state after that request.
//   cfg  - register writes (light_high, light_low, settle_ticks, ramp_step),
//          always ready; write only while no request is in flight.
// Path: a request is taken into the input register, then the state update
// loads the result register.
// Throughput: one request per cycle while res is ready; the state update is a
// single pass of compare and add logic between the input and result registers.
// Reset: all control state clears, the pulse returns to 1000 us, the fan to
// zero, auto mode on and the registers to their defaults.
// Stall: while res is held off the result register keeps its word; the input
// register still takes one more word, after which req.ready drops until the
// result is taken.
module curtain_servo_and_fan_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    cscf_req_if.sink    req,
    cscf_res_if.source  res,
    cscf_cfg_if.sink    cfg
);

    cscf_pkg::cscf_cfg_t   cfg_reg;
    cscf_pkg::cscf_item_t  item_reg;
    logic                  item_valid_reg;
    cscf_pkg::cscf_state_t state_reg;
    cscf_pkg::cscf_state_t state_next;
    logic                  res_valid_reg;
    logic                  res_free;
    logic                  advance;

    // Handshake flow
    assign res_free  = !res_valid_reg || res.ready;
    assign advance   = item_valid_reg && res_free;
    assign req.ready = !item_valid_reg || res_free;
    assign cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_high   <= cscf_pkg::LIGHT_HIGH_RST;
            cfg_reg.light_low    <= cscf_pkg::LIGHT_LOW_RST;
            cfg_reg.settle_ticks <= cscf_pkg::SETTLE_TICKS_RST;
            cfg_reg.ramp_step    <= cscf_pkg::RAMP_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cscf_pkg::CFG_LIGHT_HIGH:   cfg_reg.light_high   <= cfg.data[6:0];
                cscf_pkg::CFG_LIGHT_LOW:    cfg_reg.light_low    <= cfg.data[6:0];
                cscf_pkg::CFG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg.data[7:0];
                cscf_pkg::CFG_RAMP_STEP:    cfg_reg.ramp_step    <= cfg.data;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Hold the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (req.ready)
            item_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.req_type     <= req.req_type;
            item_reg.light_pct    <= req.light_pct;
            item_reg.temp_tenths  <= req.temp_tenths;
            item_reg.limit_open   <= req.limit_open;
            item_reg.limit_closed <= req.limit_closed;
            item_reg.window_open  <= req.window_open;
            item_reg.presence     <= req.presence;
            item_reg.rain         <= req.rain;
            item_reg.cinema       <= req.cinema;
            item_reg.vent_max     <= req.vent_max;
        end
    end

    cscf_step u_step (
        .cfg  (cfg_reg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // Advance state and load the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.manual_mode   <= 1'b0;
            state_reg.target_open   <= 1'b0;
            state_reg.physical_open <= 1'b0;
            state_reg.moving        <= 1'b0;
            state_reg.settle_count  <= 8'd0;
            state_reg.pulse         <= cscf_pkg::PULSE_MIN;
            state_reg.fan           <= 10'd0;
            res_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (res_free)
                res_valid_reg <= item_valid_reg;
        end
    end

    // Result word is the state after the last request
    assign res.valid           = res_valid_reg;
    assign res.servo_pulse     = state_reg.pulse;
    assign res.fan_level       = state_reg.fan;
    assign res.curtain_is_open = state_reg.physical_open;
    assign res.auto_on         = !state_reg.manual_mode;
    assign res.fan_on          = state_reg.fan != 10'd0;
    assign res.in_motion       = state_reg.moving;

`ifndef ASSERT_OFF
    // Servo pulse never leaves its travel range
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pulse >= cscf_pkg::PULSE_MIN && state_reg.pulse <= cscf_pkg::PULSE_MAX)
        else $error("servo pulse out of range");

    // Settle counter is cleared whenever the servo is ramping
    a_settle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.moving |-> state_reg.settle_count == 8'd0)
        else $error("settle count not cleared while moving");

    // A tick in manual mode moves nothing
    a_manual_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.req_type == cscf_pkg::REQ_TICK && state_reg.manual_mode)
        |=> $stable(state_reg.pulse) && $stable(state_reg.moving)
            && $stable(state_reg.settle_count))
        else $error("manual-mode tick changed servo state");

    // State changes only when a word advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an accepted word");

    // A stalled result keeps its word while the next one waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready && item_valid_reg) |=> item_valid_reg && res_valid_reg)
        else $error("pending word lost under stall");
`endif

endmodule

### bench/tb_curtain_servo_and_fan_controller_top.sv
`timescale 1ns / 1ps
// Testbench for curtain_servo_and_fan_controller_top: directed table, then random phases.
// Needs cscf_pkg and the three channel interfaces (cscf_req_if, cscf_res_if, cscf_cfg_if).
module tb_curtain_servo_and_fan_controller_top;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int FAN_SLOPE_X10  = 65;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [10:0] servo_pulse;
        logic [9:0]  fan_level;
        logic        curtain_is_open;
        logic        auto_on;
        logic        fan_on;
        logic        in_motion;
    } status_t;

    // One line of the directed plan: a register write or a request word
    typedef struct {
        bit                   is_cfg;
        logic [1:0]           index;
        logic [9:0]           data;
        cscf_pkg::cscf_item_t word;
        bit                   typed;
        status_t              want;
    } plan_row_t;

    logic clk;
    logic rst_n = 1'b0;

    cscf_req_if req ();
    cscf_res_if res ();
    cscf_cfg_if cfg ();

    curtain_servo_and_fan_controller_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    // Controller state as the bench sees it
    logic [6:0]  open_above;
    logic [6:0]  close_below;
    logic [7:0]  settle_limit;
    logic [9:0]  pulse_step;
    bit          manual_q;
    bit          target_q;
    bit          physical_q;
    bit          moving_q;
    logic [7:0]  settle_q;
    logic [10:0] pulse_q;
    logic [9:0]  fan_q;

    status_t   status_q[$];
    plan_row_t plan_q[$];
    int        mismatches = 0;
    bit        steady     = 1'b0;
    bit        hold_off   = 1'b0;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("status mismatch on %s: got %0d, expected %0d at %0t", what, got, want,
                     $time);
    endtask

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register write as seen by the prediction
    task automatic set_register(input logic [1:0] index, input logic [9:0] data);
        case (index)
            cscf_pkg::CFG_LIGHT_HIGH:   open_above   = data[6:0];
            cscf_pkg::CFG_LIGHT_LOW:    close_below  = data[6:0];
            cscf_pkg::CFG_SETTLE_TICKS: settle_limit = data[7:0];
            cscf_pkg::CFG_RAMP_STEP:    pulse_step   = data;
            default: ;
        endcase
    endtask

    // Advance the curtain on a 100 ms tick
    task automatic tick_servo(input bit at_open, input bit at_closed);
        int p;
        if (manual_q)
            return;
        if (moving_q)
        begin
            p = int'(pulse_q);
            if (target_q)
            begin
                if (!at_open)
                    p += int'(pulse_step);
                if (p >= int'(cscf_pkg::PULSE_MAX) || at_open)
                begin
                    if (p > int'(cscf_pkg::PULSE_MAX))
                        p = int'(cscf_pkg::PULSE_MAX);
                    moving_q   = 1'b0;
                    physical_q = 1'b1;
                end
            end
            else
            begin
                if (!at_closed)
                    p -= int'(pulse_step);
                if (p <= int'(cscf_pkg::PULSE_MIN) || at_closed)
                begin
                    if (p < int'(cscf_pkg::PULSE_MIN))
                        p = int'(cscf_pkg::PULSE_MIN);
                    moving_q   = 1'b0;
                    physical_q = 1'b0;
                end
            end
            pulse_q = p[10:0];
        end
        else if (target_q != physical_q)
        begin
            settle_q = settle_q + 8'd1;
            if (settle_q >= settle_limit)
            begin
                moving_q = 1'b1;
                settle_q = 8'd0;
            end
        end
        else
            settle_q = 8'd0;
    endtask

    // Take a sensor sample: curtain target, then fan duty
    task automatic take_sample(input cscf_pkg::cscf_item_t w);
        int t;
        int duty;
        t = int'($signed(w.temp_tenths));
        if (w.light_pct > open_above)
            target_q = 1'b1;
        else if (w.light_pct < close_below)
            target_q = 1'b0;
        if (w.rain || w.cinema)
            target_q = 1'b0;
        if (w.window_open)
            target_q = 1'b1;

        if (w.vent_max)
            fan_q = cscf_pkg::FAN_FULL;
        else if (!w.window_open && w.presence && t > int'(cscf_pkg::TEMP_ON) && !manual_q)
        begin
            duty = int'(cscf_pkg::FAN_BASE)
                   + ((t - int'(cscf_pkg::TEMP_ON)) * FAN_SLOPE_X10) / 10;
            if (duty > int'(cscf_pkg::FAN_FULL))
                duty = int'(cscf_pkg::FAN_FULL);
            fan_q = duty[9:0];
        end
        else
            fan_q = 10'd0;
    endtask

    // Apply one request word and give the status word it should produce
    task automatic apply_word(input cscf_pkg::cscf_item_t w, output status_t s);
        case (w.req_type)
            cscf_pkg::REQ_TICK:   tick_servo(w.limit_open, w.limit_closed);
            cscf_pkg::REQ_SAMPLE: take_sample(w);
            cscf_pkg::REQ_BUTTON: manual_q = !manual_q;
            default: ;
        endcase
        s.servo_pulse     = pulse_q;
        s.fan_level       = fan_q;
        s.curtain_is_open = physical_q;
        s.auto_on         = !manual_q;
        s.fan_on          = (fan_q != 10'd0);
        s.in_motion       = moving_q;
    endtask

    function automatic cscf_pkg::cscf_item_t word_of(input logic [1:0] kind, input int light,
                                                     input int temp, input bit lim_o,
                                                     input bit lim_c, input bit win,
                                                     input bit pres, input bit wet,
                                                     input bit cine, input bit vmax);
        cscf_pkg::cscf_item_t w;
        w.req_type     = kind;
        w.light_pct    = 7'(light);
        w.temp_tenths  = 12'(temp);
        w.limit_open   = lim_o;
        w.limit_closed = lim_c;
        w.window_open  = win;
        w.presence     = pres;
        w.rain         = wet;
        w.cinema       = cine;
        w.vent_max     = vmax;
        return w;
    endfunction

    function automatic status_t status_of(input int pulse, input int fan, input bit is_open,
                                          input bit auto_mode, input bit motion);
        status_t s;
        s.servo_pulse     = 11'(pulse);
        s.fan_level       = 10'(fan);
        s.curtain_is_open = is_open;
        s.auto_on         = auto_mode;
        s.fan_on          = (fan != 0);
        s.in_motion       = motion;
        return s;
    endfunction

    function automatic cscf_pkg::cscf_item_t rand_word();
        cscf_pkg::cscf_item_t w;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 56)
            w.req_type = cscf_pkg::REQ_TICK;
        else if (roll < 90)
            w.req_type = cscf_pkg::REQ_SAMPLE;
        else if (roll < 95)
            w.req_type = cscf_pkg::REQ_BUTTON;
        else
            w.req_type = REQ_SPARE;
        w.light_pct = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
        if ($urandom_range(0, 4) == 0)
            w.temp_tenths = 12'($urandom);
        else
            w.temp_tenths = 12'(int'($urandom_range(0, 2050)) - 550);
        w.limit_open   = ($urandom_range(0, 7) == 0);
        w.limit_closed = ($urandom_range(0, 7) == 0);
        w.window_open  = ($urandom_range(0, 6) == 0);
        w.presence     = ($urandom_range(0, 4) < 3);
        w.rain         = ($urandom_range(0, 6) == 0);
        w.cinema       = ($urandom_range(0, 9) == 0);
        w.vent_max     = ($urandom_range(0, 9) == 0);
        return w;
    endfunction

    task automatic plan_check(input cscf_pkg::cscf_item_t w, input status_t want);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.index  = '0;
        row.data   = '0;
        row.word   = w;
        row.typed  = 1'b1;
        row.want   = want;
        plan_q.push_back(row);
    endtask

    task automatic plan_step(input cscf_pkg::cscf_item_t w);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.index  = '0;
        row.data   = '0;
        row.word   = w;
        row.typed  = 1'b0;
        row.want   = '0;
        plan_q.push_back(row);
    endtask

    task automatic plan_cfg(input logic [1:0] index, input logic [9:0] data);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.index  = index;
        row.data   = data;
        row.word   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        plan_q.push_back(row);
    endtask

    // Offer one word, log its expected status on acceptance, then idle a while
    task automatic send_word(input cscf_pkg::cscf_item_t w, input bit typed,
                             input status_t want);
        status_t predicted;
        int gap;
        req.valid        <= 1'b1;
        req.req_type     <= w.req_type;
        req.light_pct    <= w.light_pct;
        req.temp_tenths  <= w.temp_tenths;
        req.limit_open   <= w.limit_open;
        req.limit_closed <= w.limit_closed;
        req.window_open  <= w.window_open;
        req.presence     <= w.presence;
        req.rain         <= w.rain;
        req.cinema       <= w.cinema;
        req.vent_max     <= w.vent_max;
        do @(posedge clk); while (!req.ready);
        apply_word(w, predicted);
        status_q.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every status word is back
    task automatic drain_status();
        req.valid <= 1'b0;
        do @(posedge clk); while (status_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [9:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        set_register(index, data);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [9:0] lh, input logic [9:0] ll, input logic [9:0] st,
                             input logic [9:0] step, input int count, input bit quiet,
                             input bit squeeze);
        drain_status();
        write_register(cscf_pkg::CFG_LIGHT_HIGH, lh);
        write_register(cscf_pkg::CFG_LIGHT_LOW, ll);
        write_register(cscf_pkg::CFG_SETTLE_TICKS, st);
        write_register(cscf_pkg::CFG_RAMP_STEP, step);
        steady   = quiet;
        hold_off = squeeze;
        repeat (count)
            send_word(rand_word(), 1'b0, '0);
        steady = 1'b0;
    endtask

    // Directed plan: reset values, extremes, forcing rules and each special case
    task automatic build_plan();
        plan_check(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                   status_of(1000, 0, 0, 1, 0));
        // unused request kind leaves everything alone
        plan_check(word_of(REQ_SPARE, 127, -1, 1, 1, 1, 1, 1, 1, 1),
                   status_of(1000, 0, 0, 1, 0));
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 50, 0, 0, 0, 0, 0, 0, 0, 1),
                   status_of(1000, 1000, 0, 1, 0));
        // hot sample saturates the fan
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 50, 2047, 0, 0, 0, 1, 0, 0, 0),
                   status_of(1000, 1000, 0, 1, 0));
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 50, -2048, 0, 0, 0, 1, 0, 0, 0),
                   status_of(1000, 0, 0, 1, 0));
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 50, 251, 0, 0, 0, 1, 0, 0, 0),
                   status_of(1000, 356, 0, 1, 0));
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 50, 250, 0, 0, 0, 1, 0, 0, 0),
                   status_of(1000, 0, 0, 1, 0));
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 50, 1500, 0, 0, 1, 1, 0, 0, 0),
                   status_of(1000, 0, 0, 1, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 100, 400, 0, 0, 0, 1, 1, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 127, 0, 0, 0, 0, 0, 0, 1, 0));
        // manual mode: ticks frozen, vent still forces the fan
        plan_check(word_of(cscf_pkg::REQ_BUTTON, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                   status_of(1000, 0, 0, 0, 0));
        plan_check(word_of(cscf_pkg::REQ_TICK, 0, 0, 1, 0, 0, 0, 0, 0, 0),
                   status_of(1000, 0, 0, 0, 0));
        plan_check(word_of(cscf_pkg::REQ_SAMPLE, 127, 0, 0, 0, 0, 0, 0, 0, 1),
                   status_of(1000, 1000, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 127, 800, 0, 0, 0, 1, 0, 0, 0));
        plan_check(word_of(cscf_pkg::REQ_BUTTON, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                   status_of(1000, 0, 0, 1, 0));
        // zero settle count and a ramp step that overshoots the bound
        plan_cfg(cscf_pkg::CFG_SETTLE_TICKS, 10'd0);
        plan_cfg(cscf_pkg::CFG_RAMP_STEP, 10'h3FF);
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 100, 0, 0, 0, 0, 0, 1, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero ramp step, then turn the target round mid-motion
        plan_cfg(cscf_pkg::CFG_RAMP_STEP, 10'd0);
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_TICK, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        // crossed thresholds: the open test wins
        plan_cfg(cscf_pkg::CFG_LIGHT_HIGH, 10'd10);
        plan_cfg(cscf_pkg::CFG_LIGHT_LOW, 10'd90);
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 50, 0, 0, 0, 0, 0, 0, 0, 0));
        plan_step(word_of(cscf_pkg::REQ_SAMPLE, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // Result side: take status words, check them, stall at random
    initial
    begin : status_sink
        int stall_left;
        int gap;
        status_t want;
        stall_left = 0;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (status_q.size() == 0)
                    note_mismatch("unexpected status word", 1, 0);
                else
                begin
                    want = status_q.pop_front();
                    if (res.servo_pulse !== want.servo_pulse)
                        note_mismatch("servo_pulse", res.servo_pulse, want.servo_pulse);
                    if (res.fan_level !== want.fan_level)
                        note_mismatch("fan_level", res.fan_level, want.fan_level);
                    if (res.curtain_is_open !== want.curtain_is_open)
                        note_mismatch("curtain_is_open", res.curtain_is_open,
                                      want.curtain_is_open);
                    if (res.auto_on !== want.auto_on)
                        note_mismatch("auto_on", res.auto_on, want.auto_on);
                    if (res.fan_on !== want.fan_on)
                        note_mismatch("fan_on", res.fan_on, want.fan_on);
                    if (res.in_motion !== want.in_motion)
                        note_mismatch("in_motion", res.in_motion, want.in_motion);
                end
            end
            // Decide ready for the next edge
            if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else if (hold_off)
            begin
                hold_off   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res.ready <= 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    res.ready <= 1'b1;
                else
                begin
                    stall_left = gap - 1;
                    res.ready <= 1'b0;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                idle = 0;
            else
                idle++;
        end
        $display("curtain_servo_and_fan_controller_top verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        plan_row_t row;
        req.valid        = 1'b0;
        req.req_type     = cscf_pkg::REQ_TICK;
        req.light_pct    = '0;
        req.temp_tenths  = '0;
        req.limit_open   = 1'b0;
        req.limit_closed = 1'b0;
        req.window_open  = 1'b0;
        req.presence     = 1'b0;
        req.rain         = 1'b0;
        req.cinema       = 1'b0;
        req.vent_max     = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = cscf_pkg::CFG_LIGHT_HIGH;
        cfg.data         = '0;

        // Reset values of the prediction
        open_above   = cscf_pkg::LIGHT_HIGH_RST;
        close_below  = cscf_pkg::LIGHT_LOW_RST;
        settle_limit = cscf_pkg::SETTLE_TICKS_RST;
        pulse_step   = cscf_pkg::RAMP_STEP_RST;
        manual_q     = 1'b0;
        target_q     = 1'b0;
        physical_q   = 1'b0;
        moving_q     = 1'b0;
        settle_q     = 8'd0;
        pulse_q      = cscf_pkg::PULSE_MIN;
        fan_q        = 10'd0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan
        build_plan();
        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.is_cfg)
            begin
                drain_status();
                write_register(row.index, row.data);
            end
            else
                send_word(row.word, row.typed, row.want);
        end

        // Random phases: reset-like, extremes, crossed, slow settle, narrow band, random, wide band
        run_phase(10'd70, 10'd30, 10'd2, 10'd20, 80, 1'b0, 1'b1);
        run_phase(10'h3FF, 10'h000, 10'd0, 10'h3FF, 70, 1'b1, 1'b0);
        run_phase(10'd0, 10'h3FF, 10'd1, 10'd0, 60, 1'b0, 1'b0);
        run_phase(10'd100, 10'd100, 10'h3FF, 10'd1, 60, 1'b0, 1'b0);
        run_phase(10'd60, 10'd40, 10'd3, 10'd250, 80, 1'b0, 1'b0);
        run_phase(10'($urandom), 10'($urandom), 10'($urandom_range(1, 6)),
                  10'($urandom_range(1, 600)), 80, 1'b0, 1'b0);
        run_phase(10'd85, 10'd15, 10'd1, 10'd100, 70, 1'b0, 1'b0);

        drain_status();
        if (mismatches == 0)
            $display("curtain_servo_and_fan_controller_top verification clean");
        else
            $display("curtain_servo_and_fan_controller_top verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/cscf_pkg.sv
hdl/cscf_req_if.sv
hdl/cscf_res_if.sv
hdl/cscf_cfg_if.sv
hdl/cscf_step.sv
hdl/curtain_servo_and_fan_controller_top.sv
bench/tb_curtain_servo_and_fan_controller_top.sv
